[sv/sbrt_pkg.sv]
// Package for the sparse bitmap radix tree: key slicing, node geometry,
// payload structs and the controller state type. No dependencies.
package sbrt_pkg;

    localparam int KEY_W      = 32;
    localparam int ROOT_LSB   = 26;
    localparam int MID_LSB    = 20;
    localparam int LOW_LSB    = 14;
    localparam int BYTE_LSB   = 3;
    localparam int FAN_BITS   = 6;
    localparam int FANOUT     = 64;
    localparam int BYTE_BITS  = 11;
    localparam int BIT_BITS   = 3;
    localparam int LEAF_BYTES = 2048;
    localparam int BYTE_W     = 8;

    localparam int MID_NODES_DEF  = 16;
    localparam int LOW_NODES_DEF  = 32;
    localparam int LEAF_NODES_DEF = 64;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_POOL_FULL = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
        logic             write_value;
    } t_req;

    typedef struct packed {
        logic read_bit;
        logic status;
    } t_rsp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MID,
        S_LOW,
        S_LEAF,
        S_MOD,
        S_WAIT
    } t_state;

endpackage

[sv/sbrt_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. Depends on sbrt_pkg for its default geometry.
module sbrt_ram #(
    parameter int DEPTH = sbrt_pkg::FANOUT,
    parameter int WIDTH = sbrt_pkg::BYTE_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    import sbrt_pkg::*;

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/sparse_bitmap_radix_tree.sv]
// Sparse bitmap over a 32-bit key space as a four-level radix tree held in
// four synchronous RAMs (root, middle, low, leaf). Depends on sbrt_pkg, sbrt_ram.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------
//  request | in        | i_valid / o_ready  | i_req  (t_req)
//  result  | out       | o_valid / i_ready  | o_rsp  (t_rsp)
//
// Each item walks the states in order: the accept cycle issues the root read,
// then S_MID, S_LOW and S_LEAF issue the middle, low and leaf reads, and S_MOD
// does the leaf read-modify-write with any node allocation.
// After reset a clearing pass writes every entry of all four RAMs, one entry
// a cycle, up to the depth of the largest RAM (131072 entries with the
// defaults); no request is taken until it ends.
// A stalled result waits in the output register; a finished item behind it
// waits until that register frees.
module sparse_bitmap_radix_tree #(
    parameter int MID_NODES  = sbrt_pkg::MID_NODES_DEF,
    parameter int LOW_NODES  = sbrt_pkg::LOW_NODES_DEF,
    parameter int LEAF_NODES = sbrt_pkg::LEAF_NODES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sbrt_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output sbrt_pkg::t_rsp o_rsp
);
    import sbrt_pkg::*;

    localparam int MID_IW  = (MID_NODES > 1) ? $clog2(MID_NODES) : 1;
    localparam int LOW_IW  = (LOW_NODES > 1) ? $clog2(LOW_NODES) : 1;
    localparam int LEAF_IW = (LEAF_NODES > 1) ? $clog2(LEAF_NODES) : 1;

    localparam int MID_CW  = $clog2(MID_NODES + 1);
    localparam int LOW_CW  = $clog2(LOW_NODES + 1);
    localparam int LEAF_CW = $clog2(LEAF_NODES + 1);

    localparam int MID_DEPTH  = MID_NODES * FANOUT;
    localparam int LOW_DEPTH  = LOW_NODES * FANOUT;
    localparam int LEAF_DEPTH = LEAF_NODES * LEAF_BYTES;

    localparam int ROOT_AW = FAN_BITS;
    localparam int MID_AW  = $clog2(MID_DEPTH);
    localparam int LOW_AW  = $clog2(LOW_DEPTH);
    localparam int LEAF_AW = $clog2(LEAF_DEPTH);

    // entry = {valid, child index}
    localparam int ROOT_EW = MID_IW + 1;
    localparam int MID_EW  = LOW_IW + 1;
    localparam int LOW_EW  = LEAF_IW + 1;

    localparam int CLR_D1    = (MID_DEPTH > LOW_DEPTH) ? MID_DEPTH : LOW_DEPTH;
    localparam int CLR_DEPTH = (CLR_D1 > LEAF_DEPTH) ? CLR_D1 : LEAF_DEPTH;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);

    t_state r_state, n_state;
    t_req   r_req, n_req;
    t_rsp   r_res, n_res;
    t_rsp   r_out, n_out;
    logic   r_out_valid, n_out_valid;

    logic [MID_CW-1:0]  r_mid_used, n_mid_used;
    logic [LOW_CW-1:0]  r_low_used, n_low_used;
    logic [LEAF_CW-1:0] r_leaf_used, n_leaf_used;
    logic [CLR_AW-1:0]  r_clr, n_clr;

    logic               root_we, mid_we, low_we, leaf_we;
    logic [ROOT_AW-1:0] root_wa, root_ra;
    logic [MID_AW-1:0]  mid_wa, mid_ra;
    logic [LOW_AW-1:0]  low_wa, low_ra;
    logic [LEAF_AW-1:0] leaf_wa, leaf_ra;
    logic [ROOT_EW-1:0] root_wd, root_q;
    logic [MID_EW-1:0]  mid_wd, mid_q;
    logic [LOW_EW-1:0]  low_wd, low_q;
    logic [BYTE_W-1:0]  leaf_wd, leaf_q;

    logic [FAN_BITS-1:0]  key_a, key_b, key_c;
    logic [BYTE_BITS-1:0] key_byte;
    logic [BIT_BITS-1:0]  key_bit;
    logic [BYTE_W-1:0]    bit_mask;
    logic                 have_mid, have_low, have_leaf;
    logic                 mid_full, low_full, leaf_full, fits;
    logic [MID_IW-1:0]    mid_idx, new_mid;
    logic [LOW_IW-1:0]    low_idx, new_low;
    logic [LEAF_IW-1:0]   leaf_idx, new_leaf;
    logic                 out_free;
    t_rsp                 res_now;

    sbrt_ram #(.DEPTH(FANOUT), .WIDTH(ROOT_EW)) u_root (
        .i_clk(i_clk), .i_we(root_we), .i_waddr(root_wa), .i_wdata(root_wd),
        .i_raddr(root_ra), .o_rdata(root_q)
    );
    sbrt_ram #(.DEPTH(MID_DEPTH), .WIDTH(MID_EW)) u_mid (
        .i_clk(i_clk), .i_we(mid_we), .i_waddr(mid_wa), .i_wdata(mid_wd),
        .i_raddr(mid_ra), .o_rdata(mid_q)
    );
    sbrt_ram #(.DEPTH(LOW_DEPTH), .WIDTH(LOW_EW)) u_low (
        .i_clk(i_clk), .i_we(low_we), .i_waddr(low_wa), .i_wdata(low_wd),
        .i_raddr(low_ra), .o_rdata(low_q)
    );
    sbrt_ram #(.DEPTH(LEAF_DEPTH), .WIDTH(BYTE_W)) u_leaf (
        .i_clk(i_clk), .i_we(leaf_we), .i_waddr(leaf_wa), .i_wdata(leaf_wd),
        .i_raddr(leaf_ra), .o_rdata(leaf_q)
    );

    assign key_a    = r_req.key[ROOT_LSB +: FAN_BITS];
    assign key_b    = r_req.key[MID_LSB +: FAN_BITS];
    assign key_c    = r_req.key[LOW_LSB +: FAN_BITS];
    assign key_byte = r_req.key[BYTE_LSB +: BYTE_BITS];
    assign key_bit  = r_req.key[BIT_BITS-1:0];
    assign bit_mask = BYTE_W'(1) << key_bit;

    // Read addresses follow the walk; each RAM re-reads the same entry until
    // the item finishes, so its data stays put without extra registers.
    assign mid_idx  = root_q[MID_IW-1:0];
    assign low_idx  = mid_q[LOW_IW-1:0];
    assign leaf_idx = low_q[LEAF_IW-1:0];
    assign root_ra  = (r_state == S_IDLE) ? i_req.key[ROOT_LSB +: FAN_BITS] : key_a;
    assign mid_ra   = MID_AW'({mid_idx, key_b});
    assign low_ra   = LOW_AW'({low_idx, key_c});
    assign leaf_ra  = LEAF_AW'({leaf_idx, key_byte});

    assign have_mid  = root_q[ROOT_EW-1];
    assign have_low  = have_mid && mid_q[MID_EW-1];
    assign have_leaf = have_low && low_q[LOW_EW-1];

    assign mid_full  = (r_mid_used == MID_CW'(MID_NODES));
    assign low_full  = (r_low_used == LOW_CW'(LOW_NODES));
    assign leaf_full = (r_leaf_used == LEAF_CW'(LEAF_NODES));
    assign fits      = !(!have_mid && mid_full) && !(!have_low && low_full) && !leaf_full;

    assign new_mid  = have_mid ? mid_idx : MID_IW'(r_mid_used);
    assign new_low  = have_low ? low_idx : LOW_IW'(r_low_used);
    assign new_leaf = LEAF_IW'(r_leaf_used);

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        res_now.read_bit = 1'b0;
        res_now.status   = ST_OK;
        if (r_req.req_type == REQ_READ) begin
            res_now.read_bit = have_leaf && leaf_q[key_bit];
        end else if (!have_leaf && r_req.write_value && !fits) begin
            res_now.status = ST_POOL_FULL;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_mid_used  = r_mid_used;
        n_low_used  = r_low_used;
        n_leaf_used = r_leaf_used;
        n_clr       = r_clr;
        o_ready     = 1'b0;
        root_we     = 1'b0;
        mid_we      = 1'b0;
        low_we      = 1'b0;
        leaf_we     = 1'b0;
        root_wa     = key_a;
        mid_wa      = MID_AW'({new_mid, key_b});
        low_wa      = LOW_AW'({new_low, key_c});
        leaf_wa     = leaf_ra;
        root_wd     = {1'b1, MID_IW'(r_mid_used)};
        mid_wd      = {1'b1, LOW_IW'(r_low_used)};
        low_wd      = {1'b1, new_leaf};
        leaf_wd     = leaf_q;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                root_we = (32'(r_clr) < 32'(FANOUT));
                mid_we  = (32'(r_clr) < 32'(MID_DEPTH));
                low_we  = (32'(r_clr) < 32'(LOW_DEPTH));
                leaf_we = (32'(r_clr) < 32'(LEAF_DEPTH));
                root_wa = r_clr[ROOT_AW-1:0];
                mid_wa  = r_clr[MID_AW-1:0];
                low_wa  = r_clr[LOW_AW-1:0];
                leaf_wa = r_clr[LEAF_AW-1:0];
                root_wd = '0;
                mid_wd  = '0;
                low_wd  = '0;
                leaf_wd = '0;
                n_clr   = r_clr + CLR_AW'(1);
                if (r_clr == CLR_AW'(CLR_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_req   = i_req;
                    n_state = S_MID;
                end
            end
            S_MID:  n_state = S_LOW;
            S_LOW:  n_state = S_LEAF;
            S_LEAF: n_state = S_MOD;
            S_MOD: begin
                if (r_req.req_type == REQ_WRITE) begin
                    if (have_leaf) begin
                        leaf_we = 1'b1;
                        leaf_wd = r_req.write_value ? (leaf_q | bit_mask)
                                                    : (leaf_q & ~bit_mask);
                    end else if (r_req.write_value && fits) begin
                        // allocate the missing nodes; a fresh leaf is all zero
                        root_we     = !have_mid;
                        mid_we      = !have_low;
                        low_we      = 1'b1;
                        leaf_we     = 1'b1;
                        leaf_wa     = LEAF_AW'({new_leaf, key_byte});
                        leaf_wd     = bit_mask;
                        n_mid_used  = r_mid_used + MID_CW'(!have_mid);
                        n_low_used  = r_low_used + LOW_CW'(!have_low);
                        n_leaf_used = r_leaf_used + LEAF_CW'(1);
                    end
                end
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = res_now;
                    n_state     = S_IDLE;
                end else begin
                    n_res   = res_now;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_mid_used  <= '0;
            r_low_used  <= '0;
            r_leaf_used <= '0;
            r_clr       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_mid_used  <= n_mid_used;
            r_low_used  <= n_low_used;
            r_leaf_used <= n_leaf_used;
            r_clr       <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

`ifndef SYNTHESIS
    a_pool_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_used <= MID_CW'(MID_NODES)) && (r_low_used <= LOW_CW'(LOW_NODES))
        && (r_leaf_used <= LEAF_CW'(LEAF_NODES)))
        else $error("node pool count beyond pool size");

    a_leaf_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_leaf_used != $past(r_leaf_used)))
        |-> (r_leaf_used == $past(r_leaf_used) + LEAF_CW'(1)))
        else $error("leaf pool count moved by other than one");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status == ST_POOL_FULL)) |-> (mid_full || low_full || leaf_full))
        else $error("pool exhausted reported with room in every pool");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (($past(r_state) == S_MOD) || ($past(r_state) == S_WAIT)))
        else $error("result raised outside the finishing states");
`endif

endmodule
